// File: rtl/core/wscs_pkg.sv
// Shared types and codes for the window/screen crop selector.
// Request and result payloads, screen table entry and scan interface structs.
// No dependencies.
package wscs_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [2:0]         entry_index;
        logic signed [15:0] screen_left;
        logic signed [15:0] screen_top;
        logic signed [15:0] screen_right;
        logic signed [15:0] screen_bottom;
        logic signed [15:0] win_x;
        logic signed [15:0] win_y;
        logic [14:0]        win_width;
        logic [14:0]        win_height;
    } req_t;

    typedef struct packed {
        logic signed [15:0] crop_left;
        logic signed [15:0] crop_top;
        logic signed [15:0] crop_right;
        logic signed [15:0] crop_bottom;
        logic [2:0]         screen_hit;
        logic               found;
    } res_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
    } screen_t;

    localparam int SCREEN_W = $bits(screen_t);

    typedef struct packed {
        logic               start;
        logic signed [15:0] win_x;
        logic signed [15:0] win_y;
        logic [14:0]        win_width;
        logic [14:0]        win_height;
    } scan_cmd_t;

    typedef struct packed {
        logic               done;
        logic               found;
        logic [2:0]         hit;
        logic signed [15:0] crop_left;
        logic signed [15:0] crop_top;
        logic signed [15:0] crop_right;
        logic signed [15:0] crop_bottom;
    } scan_res_t;

endpackage

// File: rtl/core/wscs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth set by parameters; no dependencies.
module wscs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/wscs_scan.sv
// Screen table walker: reads each active entry, intersects it with the window,
// computes the overlap area and keeps the best candidate. Uses wscs_pkg.
module wscs_scan #(
    parameter int MAX_SCREENS = 8,
    localparam int IDX_W = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1,
    localparam int CNT_W = ($clog2(MAX_SCREENS + 1) > 4) ? $clog2(MAX_SCREENS + 1) : 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wscs_pkg::scan_cmd_t   cmd,
    input  logic [CNT_W-1:0]      count,
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_addr,
    input  wscs_pkg::screen_t     rd_data,
    output wscs_pkg::scan_res_t   res
);

    import wscs_pkg::*;

    logic               active_reg, active_next;
    logic               issuing_reg, issuing_next;
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic signed [15:0] wx_reg, wy_reg;
    logic signed [16:0] wx2_reg, wy2_reg;

    logic               v1_reg;
    logic [IDX_W-1:0]   idx1_reg;

    logic               v2_reg, ne2_reg;
    logic [IDX_W-1:0]   idx2_reg;
    logic signed [15:0] l2_reg, t2_reg, r2_reg, b2_reg;
    logic [15:0]        w2_reg, h2_reg;

    logic               v3_reg, ne3_reg;
    logic [IDX_W-1:0]   idx3_reg;
    logic signed [15:0] l3_reg, t3_reg, r3_reg, b3_reg;
    logic [31:0]        area3_reg;

    logic               found_reg;
    logic [31:0]        best_area_reg;
    logic [IDX_W-1:0]   hit_reg;
    logic signed [15:0] bl_reg, bt_reg, br_reg, bb_reg;

    logic signed [15:0] sl, st, cl, ct;
    logic signed [16:0] sr, sb, cr, cb, cl17, ct17, cw, ch;
    logic               ne1, done, take;

    // Control and read issue
    always_comb
    begin
        active_next  = active_reg;
        issuing_next = issuing_reg;
        rd_cnt_next  = rd_cnt_reg;
        count_next   = count_reg;
        if (cmd.start)
        begin
            active_next  = 1'b1;
            issuing_next = (count != '0);
            rd_cnt_next  = '0;
            count_next   = count;
        end
        else
        begin
            if (issuing_reg)
            begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_next == count_reg)
                begin
                    issuing_next = 1'b0;
                end
            end
            if (done)
            begin
                active_next = 1'b0;
            end
        end
    end

    assign done    = active_reg && !issuing_reg && !v1_reg && !v2_reg && !v3_reg;
    assign rd_en   = issuing_reg;
    assign rd_addr = rd_cnt_reg[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            issuing_reg <= 1'b0;
            rd_cnt_reg  <= '0;
            count_reg   <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            issuing_reg <= issuing_next;
            rd_cnt_reg  <= rd_cnt_next;
            count_reg   <= count_next;
            v1_reg      <= issuing_reg && !cmd.start;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            if (cmd.start)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // Intersection of the read entry with the window
    always_comb
    begin
        sl   = rd_data.left;
        st   = rd_data.top;
        sr   = $signed({rd_data.right[15], rd_data.right});
        sb   = $signed({rd_data.bottom[15], rd_data.bottom});
        cl   = (sl > wx_reg) ? sl : wx_reg;
        ct   = (st > wy_reg) ? st : wy_reg;
        cr   = (sr < wx2_reg) ? sr : wx2_reg;
        cb   = (sb < wy2_reg) ? sb : wy2_reg;
        cl17 = $signed({cl[15], cl});
        ct17 = $signed({ct[15], ct});
        ne1  = (cl17 < cr) && (ct17 < cb);
        cw   = cr - cl17;
        ch   = cb - ct17;
    end

    assign take = v3_reg && ne3_reg && (!found_reg || (area3_reg >= best_area_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            wx_reg  <= cmd.win_x;
            wy_reg  <= cmd.win_y;
            wx2_reg <= $signed({cmd.win_x[15], cmd.win_x}) + $signed({2'b00, cmd.win_width});
            wy2_reg <= $signed({cmd.win_y[15], cmd.win_y}) + $signed({2'b00, cmd.win_height});
            bl_reg  <= '0;
            bt_reg  <= '0;
            br_reg  <= $signed({1'b0, cmd.win_width});
            bb_reg  <= $signed({1'b0, cmd.win_height});
            hit_reg <= '0;
            best_area_reg <= '0;
        end
        else if (take)
        begin
            bl_reg        <= l3_reg;
            bt_reg        <= t3_reg;
            br_reg        <= r3_reg;
            bb_reg        <= b3_reg;
            hit_reg       <= idx3_reg;
            best_area_reg <= area3_reg;
        end

        idx1_reg <= rd_cnt_reg[IDX_W-1:0];

        idx2_reg <= idx1_reg;
        ne2_reg  <= ne1;
        l2_reg   <= cl;
        t2_reg   <= ct;
        r2_reg   <= cr[15:0];
        b2_reg   <= cb[15:0];
        w2_reg   <= cw[15:0];
        h2_reg   <= ch[15:0];

        idx3_reg  <= idx2_reg;
        ne3_reg   <= ne2_reg;
        l3_reg    <= l2_reg;
        t3_reg    <= t2_reg;
        r3_reg    <= r2_reg;
        b3_reg    <= b2_reg;
        area3_reg <= w2_reg * h2_reg;
    end

    always_comb
    begin
        res.done        = done;
        res.found       = found_reg;
        res.hit         = 3'(hit_reg);
        res.crop_left   = bl_reg;
        res.crop_top    = bt_reg;
        res.crop_right  = br_reg;
        res.crop_bottom = bb_reg;
    end

endmodule

// File: rtl/core/window_screen_crop_select.sv
// Window/screen crop selector top level: request decode, screen table RAM,
// table walker, trim to multiples of 8 and result register. Uses wscs_pkg.
// Load request: written to the table RAM at acceptance, no result.
// Query request: the walker issues one table read per cycle for count entries, where count is
// the clamped screen count, then drains the walk tail; the trimmed result is then registered.
// Next request accepted the cycle after the result is registered and the output is free.
// Reset clears control state and screen_count; table entries undefined until loaded.
module window_screen_crop_select #(
    parameter int MAX_SCREENS = 8,
    localparam int IDX_W = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1,
    localparam int CNT_W = ($clog2(MAX_SCREENS + 1) > 4) ? $clog2(MAX_SCREENS + 1) : 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  wscs_pkg::req_t req_data,
    output logic           res_valid,
    input  logic           res_stall,
    output wscs_pkg::res_t res_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [3:0]     cfg_data
);

    import wscs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic signed [15:0] lo;
        logic signed [15:0] hi;
    } edge_pair_t;

    state_t           state_reg, state_next;
    logic [3:0]       screen_count_reg;
    logic             res_valid_reg, res_valid_next;
    res_t             res_data_reg, res_data_next;

    logic             accept, load_wr;
    logic [CNT_W-1:0] cnt_ext, cnt_eff;
    scan_cmd_t        scan_cmd;
    scan_res_t        scan_res;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    screen_t          wr_entry;
    logic [SCREEN_W-1:0] rd_word;
    edge_pair_t       trim_x, trim_y;

    function automatic edge_pair_t trim8(input logic signed [15:0] lo,
                                         input logic signed [15:0] hi);
        logic signed [16:0] span;
        logic [2:0]         r;
        edge_pair_t         p;
        span = $signed({hi[15], hi}) - $signed({lo[15], lo});
        r    = span[2:0];
        p.lo = lo;
        p.hi = hi;
        if (!span[16] && (r != 3'd0) && (hi > 16'sd0))
        begin
            p.hi = hi - {14'd0, r[2:1]};
            p.lo = lo + {14'd0, r[2:1]} + {15'd0, r[0]};
        end
        return p;
    endfunction

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign load_wr   = accept && (req_data.cmd == CMD_LOAD)
                       && (32'(req_data.entry_index) < MAX_SCREENS);
    assign cfg_ready = 1'b1;

    // Clamp the active count to the table depth
    assign cnt_ext = CNT_W'(screen_count_reg);
    assign cnt_eff = (cnt_ext > CNT_W'(MAX_SCREENS)) ? CNT_W'(MAX_SCREENS) : cnt_ext;

    always_comb
    begin
        scan_cmd.start      = accept && (req_data.cmd == CMD_QUERY);
        scan_cmd.win_x      = req_data.win_x;
        scan_cmd.win_y      = req_data.win_y;
        scan_cmd.win_width  = req_data.win_width;
        scan_cmd.win_height = req_data.win_height;
        wr_entry.left       = req_data.screen_left;
        wr_entry.top        = req_data.screen_top;
        wr_entry.right      = req_data.screen_right;
        wr_entry.bottom     = req_data.screen_bottom;
    end

    wscs_ram #(
        .WIDTH (SCREEN_W),
        .DEPTH (MAX_SCREENS)
    ) u_table (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (IDX_W'(req_data.entry_index)),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    wscs_scan #(
        .MAX_SCREENS (MAX_SCREENS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (scan_cmd),
        .count   (cnt_eff),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (screen_t'(rd_word)),
        .res     (scan_res)
    );

    assign trim_x = trim8(scan_res.crop_left, scan_res.crop_right);
    assign trim_y = trim8(scan_res.crop_top, scan_res.crop_bottom);

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (scan_cmd.start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_res.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the result register is free
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next            = 1'b1;
                    res_data_next.crop_left   = trim_x.lo;
                    res_data_next.crop_right  = trim_x.hi;
                    res_data_next.crop_top    = trim_y.lo;
                    res_data_next.crop_bottom = trim_y.hi;
                    res_data_next.screen_hit  = scan_res.hit;
                    res_data_next.found       = scan_res.found;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            screen_count_reg <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                screen_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule
